>>> rtl/core/mbps_pkg.sv
// Shared types and constants for the masked byte pattern search core.
`default_nettype none
package mbps_pkg;

  localparam int PAT_MAX   = 32;
  localparam int PAT_IDX_W = $clog2(PAT_MAX);
  localparam int LEN_W     = PAT_IDX_W + 1;
  localparam int POS_W     = 32;
  localparam int OCC_W     = 16;
  localparam int S_DATA_W  = 24;
  localparam int M_DATA_W  = 32;
  localparam int APB_AW    = 4;
  localparam int APB_DW    = 32;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_DATA = 1'b1;

  localparam logic STATUS_FOUND     = 1'b0;
  localparam logic STATUS_NOT_FOUND = 1'b1;

  localparam logic [1:0] REG_PATTERN_LENGTH = 2'd0;
  localparam logic [1:0] REG_MATCH_OFFSET   = 2'd1;
  localparam logic [1:0] REG_OCCURRENCE     = 2'd2;

  typedef struct packed {
    logic [LEN_W-1:0] pattern_length;
    logic [LEN_W-1:0] match_offset;
    logic [OCC_W-1:0] occurrence;
  } cfg_t;

  typedef struct packed {
    logic                 op;
    logic [PAT_IDX_W-1:0] pattern_index;
    logic [7:0]           pattern_value;
    logic                 pattern_care;
    logic [7:0]           data_byte;
    logic                 last;
  } item_t;

  typedef struct packed {
    logic  go;
    item_t item;
  } match_ctl_t;

endpackage
`default_nettype wire

>>> rtl/core/mbps_cfg_regs.sv
// Configuration register bank with its APB-style access port.
`default_nettype none
module mbps_cfg_regs
  import mbps_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [APB_AW-1:0] paddr,
  input  wire logic [APB_DW-1:0] pwdata,
  output logic      [APB_DW-1:0] prdata,
  output logic                   pready,
  output cfg_t                   cfg
);

  logic       wr_en;
  logic [1:0] reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_sel = paddr[3:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pattern_length <= '0;
      cfg.match_offset   <= '0;
      cfg.occurrence     <= OCC_W'(1);
    end else if (wr_en) begin
      unique case (reg_sel)
        REG_PATTERN_LENGTH: cfg.pattern_length <= pwdata[LEN_W-1:0];
        REG_MATCH_OFFSET:   cfg.match_offset   <= pwdata[LEN_W-1:0];
        REG_OCCURRENCE:     cfg.occurrence     <= pwdata[OCC_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_PATTERN_LENGTH: prdata = APB_DW'(cfg.pattern_length);
      REG_MATCH_OFFSET:   prdata = APB_DW'(cfg.match_offset);
      REG_OCCURRENCE:     prdata = APB_DW'(cfg.occurrence);
      default:            prdata = '0;
    endcase
  end

endmodule
`default_nettype wire

>>> rtl/core/mbps_match_unit.sv
// Pattern store, byte window and parallel masked compare of all entries.
`default_nettype none
module mbps_match_unit
  import mbps_pkg::*;
(
  input  wire logic             clk,
  input  wire match_ctl_t       ctl,
  input  wire logic [LEN_W-1:0] len,
  output logic                  hit
);

  logic [7:0]         win      [PAT_MAX];
  logic [7:0]         win_next [PAT_MAX];
  logic [7:0]         pat_val  [PAT_MAX];
  logic [PAT_MAX-1:0] pat_care;
  logic [PAT_MAX-1:0] ok;

  always_comb begin
    win_next[0] = ctl.item.data_byte;
    for (int k = 1; k < PAT_MAX; k++) begin
      win_next[k] = win[k-1];
    end
  end

  // Entry j lines up with the byte that arrived len-1-j bytes ago.
  always_comb begin
    for (int j = 0; j < PAT_MAX; j++) begin
      logic [PAT_IDX_W-1:0] tap;
      tap   = PAT_IDX_W'(len - LEN_W'(1) - LEN_W'(j));
      ok[j] = (LEN_W'(j) >= len) || !pat_care[j] || (pat_val[j] == win_next[tap]);
    end
  end

  assign hit = &ok;

  always_ff @(posedge clk) begin
    if (ctl.go && ctl.item.op == OP_DATA) begin
      for (int k = 0; k < PAT_MAX; k++) begin
        win[k] <= win_next[k];
      end
    end
    if (ctl.go && ctl.item.op == OP_LOAD) begin
      pat_val[ctl.item.pattern_index]  <= ctl.item.pattern_value;
      pat_care[ctl.item.pattern_index] <= ctl.item.pattern_care;
    end
  end

endmodule
`default_nettype wire

>>> rtl/core/masked_byte_pattern_search_core.sv
// Top level of the masked byte pattern search core: item staging, counters and result.
//
//  Channel  Direction  Handshake          Contents
//  s_*      in         tvalid/tready      one item: pattern entry load or data byte
//  m_*      out        tvalid/tready      one result: found position or not found
//  apb      in/out     psel/penable       pattern_length, match_offset, occurrence
//
// An item is registered on acceptance and processed once the output register is
// free or being read; its result is then registered in the output register.
// One item is accepted per cycle while the output side takes results; the output
// register is the only point of backpressure. Reset clears the counters, the item
// stage and the result valid, and sets the registers (occurrence to one, the others
// to zero); the pattern store is undefined until loaded.
`default_nettype none
module masked_byte_pattern_search_core
  import mbps_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                s_tvalid,
  output logic                     s_tready,
  // [4:0] pattern_index, [12:5] pattern_value, [13] pattern_care, [21:14] data_byte
  input  wire logic [S_DATA_W-1:0] s_tdata,
  // [0] op
  input  wire logic                s_tuser,
  input  wire logic                s_tlast,
  output logic                     m_tvalid,
  input  wire logic                m_tready,
  // [31:0] match_position
  output logic      [M_DATA_W-1:0] m_tdata,
  // [0] status
  output logic                     m_tuser,
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [APB_AW-1:0]   paddr,
  input  wire logic [APB_DW-1:0]   pwdata,
  output logic      [APB_DW-1:0]   prdata,
  output logic                     pready
);

  cfg_t             cfg;
  item_t            item;
  logic             item_valid;
  logic             go;
  logic             hit;
  match_ctl_t       ctl;
  logic [LEN_W-1:0] len;

  logic [POS_W-1:0] bytes_seen;
  logic [POS_W-1:0] bytes_seen_next;
  logic [OCC_W-1:0] matches_found;
  logic [OCC_W-1:0] matches_found_next;
  logic             region_done;
  logic             hit_ok;
  logic             found;
  logic             emit;
  logic [POS_W:0]   pos_sum;
  logic [POS_W-1:0] pos;
  logic             is_data;

  mbps_cfg_regs u_cfg_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  assign go       = item_valid && (!m_tvalid || m_tready);
  assign s_tready = !item_valid || go;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (s_tready) begin
      item_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      item.op            <= s_tuser;
      item.pattern_index <= s_tdata[4:0];
      item.pattern_value <= s_tdata[12:5];
      item.pattern_care  <= s_tdata[13];
      item.data_byte     <= s_tdata[21:14];
      item.last          <= s_tlast;
    end
  end

  assign len = (cfg.pattern_length > LEN_W'(PAT_MAX)) ? LEN_W'(PAT_MAX)
                                                      : cfg.pattern_length;

  assign ctl.go   = go;
  assign ctl.item = item;

  mbps_match_unit u_match_unit (
    .clk (clk),
    .ctl (ctl),
    .len (len),
    .hit (hit)
  );

  assign is_data         = go && (item.op == OP_DATA);
  assign bytes_seen_next = (&bytes_seen) ? bytes_seen : bytes_seen + POS_W'(1);

  assign hit_ok = !region_done && (len != '0) && (cfg.occurrence != '0)
                  && (bytes_seen_next >= POS_W'(len)) && hit;

  assign matches_found_next = (hit_ok && !(&matches_found)) ? matches_found + OCC_W'(1)
                                                            : matches_found;

  assign found   = hit_ok && (matches_found_next == cfg.occurrence);
  assign emit    = found || (item.last && !region_done);
  assign pos_sum = {1'b0, bytes_seen_next} - (POS_W+1)'(len) + (POS_W+1)'(cfg.match_offset);
  assign pos     = pos_sum[POS_W] ? '1 : pos_sum[POS_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_seen    <= '0;
      matches_found <= '0;
      region_done   <= 1'b0;
    end else if (is_data) begin
      if (item.last) begin
        bytes_seen    <= '0;
        matches_found <= '0;
        region_done   <= 1'b0;
      end else begin
        bytes_seen    <= bytes_seen_next;
        matches_found <= matches_found_next;
        region_done   <= region_done || found;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (is_data && emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (is_data && emit) begin
      m_tuser <= found ? STATUS_FOUND : STATUS_NOT_FOUND;
      m_tdata <= found ? M_DATA_W'(pos) : '0;
    end
  end

  a_not_found_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == STATUS_NOT_FOUND) |-> m_tdata == '0)
    else $error("not-found result carries a non-zero position");

  a_region_clear: assert property (@(posedge clk) disable iff (rst)
    is_data && item.last |=> !region_done && bytes_seen == '0 && matches_found == '0)
    else $error("region state not cleared after the last byte");

  a_found_done: assert property (@(posedge clk) disable iff (rst)
    is_data && found && !item.last |=> region_done)
    else $error("region not marked done after a reported match");

  a_emit_valid: assert property (@(posedge clk) disable iff (rst)
    is_data && emit |=> m_tvalid)
    else $error("result lost on the output register");

  a_no_hit_after_done: assert property (@(posedge clk) disable iff (rst)
    region_done |-> !found)
    else $error("second match reported in one region");

endmodule
`default_nettype wire

>>> tb/sv/tb_top.sv
// Self-checking testbench for masked_byte_pattern_search_core with a stream driver and a monitor.
`timescale 1ns / 1ps

module tb_top;
  import mbps_pkg::*;

  localparam int CYCLE_LIMIT  = 300000;
  localparam int RANDOM_ITEMS = 1400;
  localparam int LONG_STALL   = 300;

  typedef struct {
    logic        status;
    logic [31:0] position;
  } search_result_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  // [4:0] pattern_index, [12:5] pattern_value, [13] pattern_care, [21:14] data_byte
  logic [S_DATA_W-1:0] s_tdata = '0;
  // [0] op
  logic                s_tuser = 1'b0;
  logic                s_tlast = 1'b0;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  // [31:0] match_position
  logic [M_DATA_W-1:0] m_tdata;
  // [0] status
  logic                m_tuser;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [APB_AW-1:0]   paddr = '0;
  logic [APB_DW-1:0]   pwdata = '0;
  logic [APB_DW-1:0]   prdata;
  logic                pready;

  // Predictor state.
  logic [7:0]  win_bytes [PAT_MAX];
  logic [7:0]  pat_val [PAT_MAX];
  logic        pat_care [PAT_MAX];
  logic [31:0] region_bytes;
  logic [15:0] region_matches;
  logic        region_reported;
  logic [5:0]  cfg_len;
  logic [5:0]  cfg_off;
  logic [15:0] cfg_occ;

  // Copy of the pattern as loaded by the stimulus, used to plant matches.
  logic [7:0]  plant_val [PAT_MAX];
  logic        plant_care [PAT_MAX];

  item_t          item_backlog [$];
  search_result_t expected_results [$];
  logic [7:0]     region_buf [$];
  item_t          offered_item;
  search_result_t oldest_result;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int stall_req = 0;
  int stall_ack = 0;
  int stall_left = 0;
  int items_queued = 0;
  int items_taken = 0;
  int results_checked = 0;
  int settings_used = 0;
  int failures = 0;
  int cycle_count = 0;

  masked_byte_pattern_search_core i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always #5 clk = ~clk;

  function automatic void predict_search(input item_t it);
    int unsigned eff_len;
    int          k;
    logic        hit;
    logic        reported;
    logic [32:0] pos;
    search_result_t res;
    if (it.op == OP_LOAD) begin
      pat_val[it.pattern_index] = it.pattern_value;
      pat_care[it.pattern_index] = it.pattern_care;
      return;
    end
    for (k = PAT_MAX - 1; k > 0; k--) win_bytes[k] = win_bytes[k-1];
    win_bytes[0] = it.data_byte;
    if (region_bytes != 32'hFFFF_FFFF) region_bytes++;
    eff_len = (cfg_len > PAT_MAX) ? PAT_MAX : cfg_len;
    reported = 1'b0;
    if (!region_reported && eff_len != 0 && cfg_occ != 0 && region_bytes >= eff_len) begin
      hit = 1'b1;
      for (k = 0; k < eff_len; k++) begin
        if (pat_care[k] && pat_val[k] != win_bytes[eff_len-1-k]) hit = 1'b0;
      end
      if (hit) begin
        if (region_matches != 16'hFFFF) region_matches++;
        if (region_matches == cfg_occ) begin
          pos = {1'b0, region_bytes} - 33'(eff_len) + 33'(cfg_off);
          res.status = STATUS_FOUND;
          res.position = pos[32] ? 32'hFFFF_FFFF : pos[31:0];
          expected_results.insert(expected_results.size(), res);
          region_reported = 1'b1;
          reported = 1'b1;
        end
      end
    end
    if (it.last) begin
      if (!reported && !region_reported) begin
        res.status = STATUS_NOT_FOUND;
        res.position = '0;
        expected_results.insert(expected_results.size(), res);
      end
      for (k = 0; k < PAT_MAX; k++) win_bytes[k] = 8'h00;
      region_bytes = '0;
      region_matches = '0;
      region_reported = 1'b0;
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        predict_search(offered_item);
        items_taken++;
      end
      if (!s_tvalid || s_tready) begin
        if (item_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          offered_item = item_backlog.pop_front();
          s_tvalid <= 1'b1;
          s_tdata <= {2'b00, offered_item.data_byte, offered_item.pattern_care,
                      offered_item.pattern_value, offered_item.pattern_index};
          s_tuser <= offered_item.op;
          s_tlast <= offered_item.last;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (stall_ack != stall_req) begin
      stall_ack <= stall_req;
      stall_left <= LONG_STALL;
      m_tready <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (expected_results.size() == 0) begin
        $error("Result with nothing expected: status %0d position %0d", m_tuser, m_tdata);
        failures++;
      end else begin
        oldest_result = expected_results.pop_front();
        if (m_tuser !== oldest_result.status) begin
          $error("status: expected %0d, got %0d", oldest_result.status, m_tuser);
          failures++;
        end
        if (m_tdata !== oldest_result.position) begin
          $error("match_position: expected %0d, got %0d", oldest_result.position, m_tdata);
          failures++;
        end
        results_checked++;
      end
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Run stopped after %0d cycles.", cycle_count);
    $display("[masked_byte_pattern_search_core] ERROR");
    $finish;
  end

  task automatic push_load(input int idx, input int val, input int care);
    item_t it;
    it = '0;
    it.op = OP_LOAD;
    it.pattern_index = idx[PAT_IDX_W-1:0];
    it.pattern_value = val[7:0];
    it.pattern_care = care[0];
    plant_val[idx] = val[7:0];
    plant_care[idx] = care[0];
    item_backlog.insert(item_backlog.size(), it);
    items_queued++;
  endtask

  task automatic push_byte(input int val, input logic fin);
    item_t it;
    it = '0;
    it.op = OP_DATA;
    it.data_byte = val[7:0];
    it.last = fin;
    item_backlog.insert(item_backlog.size(), it);
    items_queued++;
  endtask

  task automatic wait_idle();
    while (item_backlog.size() != 0 || s_tvalid || expected_results.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic reg_write(input logic [1:0] idx, input logic [31:0] val);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_PATTERN_LENGTH: cfg_len = val[5:0];
      REG_MATCH_OFFSET:   cfg_off = val[5:0];
      REG_OCCURRENCE:     cfg_occ = val[15:0];
      default: ;
    endcase
  endtask

  task automatic set_search(input int len, input int off, input int occ);
    wait_idle();
    reg_write(REG_PATTERN_LENGTH, len);
    reg_write(REG_MATCH_OFFSET, off);
    reg_write(REG_OCCURRENCE, occ);
    settings_used++;
  endtask

  task automatic send_region(input int eff, input int rlen, input int plants, input bit dense);
    int k;
    int j;
    int start;
    region_buf.delete();
    for (k = 0; k < rlen; k++) begin
      if (dense && eff != 0 && $urandom_range(1))
        region_buf.insert(region_buf.size(), plant_val[$urandom_range(eff - 1)]);
      else
        region_buf.insert(region_buf.size(), 8'($urandom_range(255)));
    end
    if (eff != 0 && rlen >= eff) begin
      for (k = 0; k < plants; k++) begin
        start = $urandom_range(rlen - eff);
        for (j = 0; j < eff; j++) begin
          if (plant_care[j]) region_buf[start + j] = plant_val[j];
        end
      end
    end
    for (k = 0; k < rlen; k++) begin
      if ($urandom_range(59) == 0)
        push_load($urandom_range(PAT_MAX - 1), $urandom_range(255), $urandom_range(1));
      push_byte(region_buf[k], k == rlen - 1);
    end
  endtask

  initial begin
    int k;
    int r;
    int len;
    int eff;
    int off;
    int occ;
    int base;
    int nreg;
    bit all_wild;
    bit stalled;
    for (k = 0; k < PAT_MAX; k++) begin
      win_bytes[k] = 8'h00;
      pat_val[k] = 8'h00;
      pat_care[k] = 1'b0;
    end
    region_bytes = '0;
    region_matches = '0;
    region_reported = 1'b0;
    cfg_len = '0;
    cfg_off = '0;
    cfg_occ = 16'd1;
    stalled = 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    send_idle_pct = 25;
    recv_idle_pct = 50;
    for (k = 0; k < PAT_MAX; k++) push_load(k, $urandom_range(255), 1);
    // Zero length after reset: the region must end with not found.
    push_byte(8'h00, 1'b0);
    push_byte(8'hFF, 1'b1);
    set_search(3, 0, 1);
    push_load(0, 8'hAA, 1);
    push_load(1, 8'h00, 0);
    push_load(2, 8'h55, 1);
    // Found mid-region; the bytes after it and the region end stay silent.
    push_byte(8'h11, 1'b0);
    push_byte(8'hAA, 1'b0);
    push_byte(8'h7E, 1'b0);
    push_byte(8'h55, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'h00, 1'b1);
    // Region shorter than the pattern.
    push_byte(8'hAA, 1'b0);
    push_byte(8'h55, 1'b1);
    // Match on the final byte.
    push_byte(8'hAA, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'h55, 1'b1);
    set_search(3, 32, 2);
    push_byte(8'hAA, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'h55, 1'b0);
    push_byte(8'hAA, 1'b0);
    push_byte(8'h01, 1'b0);
    push_byte(8'h55, 1'b1);
    set_search(1, 63, 0);
    push_byte(8'hAA, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'hFF, 1'b1);

    base = items_queued;
    while (items_queued - base < RANDOM_ITEMS) begin
      if (items_queued - base < RANDOM_ITEMS / 3) begin
        send_idle_pct = 25;
        recv_idle_pct = 50;
      end else if (items_queued - base < 2 * RANDOM_ITEMS / 3) begin
        send_idle_pct = 50;
        recv_idle_pct = 25;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      r = $urandom_range(99);
      if (r < 5) len = 0;
      else if (r < 10) len = PAT_MAX;
      else if (r < 13) len = $urandom_range(PAT_MAX + 1, 63);
      else len = $urandom_range(1, 6);
      r = $urandom_range(99);
      if (r < 10) off = 32;
      else if (r < 14) off = 63;
      else off = $urandom_range(0, 8);
      r = $urandom_range(99);
      if (r < 8) occ = 0;
      else if (r < 12) occ = 65535;
      else occ = $urandom_range(1, 3);
      set_search(len, off, occ);
      eff = (len > PAT_MAX) ? PAT_MAX : len;
      all_wild = ($urandom_range(9) == 0);
      for (k = 0; k < eff; k++)
        push_load(k, $urandom_range(255), all_wild ? 0 : ($urandom_range(3) != 0));
      nreg = $urandom_range(2, 5);
      for (k = 0; k < nreg; k++)
        send_region(eff, $urandom_range(1, eff + 20), $urandom_range(0, 3),
                    $urandom_range(2) == 0);
      if (!stalled && items_queued - base >= RANDOM_ITEMS / 2) begin
        // Hold the output off while the backlog is still being offered.
        stall_req = stall_req + 1;
        stalled = 1'b1;
      end
    end

    while (item_backlog.size() != 0 || s_tvalid) @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    $display("Summary: %0d items accepted, %0d results checked, %0d register settings.",
             items_taken, results_checked, settings_used);
    $display("Covered wildcard and literal entries, overlapping and planted matches,");
    $display("zero and oversized lengths, zero occurrence and a long output stall.");
    if (failures == 0 && expected_results.size() == 0) begin
      $display("[masked_byte_pattern_search_core] OK");
    end else begin
      $display("[masked_byte_pattern_search_core] ERROR");
    end
    $finish;
  end

endmodule
